/* design/wslm_pkg.sv */
// wslm_pkg: shared types, codes and constants of the station link manager
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package wslm_pkg;

  // default parameter values
  localparam int SCAN_LIST_LEN_DEF = 19;
  localparam int TIME_BITS_DEF     = 16;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_ASSOC_RETRY      = 2'd0;
  localparam logic [1:0] REG_SCAN_DWELL           = 2'd1;
  localparam logic [1:0] REG_ASSOC_RETRY_INTERVAL = 2'd2;
  localparam logic [1:0] REG_KEEPALIVE_LIMIT      = 2'd3;

  // configuration reset values
  localparam logic [7:0]  MAX_ASSOC_RETRY_RST      = 8'd5;
  localparam logic [15:0] SCAN_DWELL_RST           = 16'd6;
  localparam logic [15:0] ASSOC_RETRY_INTERVAL_RST = 16'd20;
  localparam logic [15:0] KEEPALIVE_LIMIT_RST      = 16'd7200;  // two hours of seconds

  // requested mode codes
  localparam logic [1:0] REQ_DISABLED = 2'd0;
  localparam logic [1:0] REQ_SCAN     = 2'd2;

  // authentication levels
  localparam logic [1:0] AUTH_DISCONNECTED = 2'd0;
  localparam logic [1:0] AUTH_DEASSOC      = 2'd1;
  localparam logic [1:0] AUTH_AUTHENTIC    = 2'd2;
  localparam logic [1:0] AUTH_ASSOCIATED   = 2'd3;

  // led patterns
  localparam logic [1:0] LED_ON   = 2'd0;
  localparam logic [1:0] LED_SLOW = 2'd1;
  localparam logic [1:0] LED_FAST = 2'd2;

  // reported mode codes
  localparam logic [2:0] MODE_CODE_DISABLED   = 3'd0;
  localparam logic [2:0] MODE_CODE_NORMAL     = 3'd1;
  localparam logic [2:0] MODE_CODE_SCAN       = 3'd2;
  localparam logic [2:0] MODE_CODE_ASSOCIATE  = 3'd3;
  localparam logic [2:0] MODE_CODE_ASSOCIATED = 3'd4;
  localparam logic [2:0] MODE_CODE_CANNOT     = 3'd5;

  localparam logic [3:0] CHANNEL_MIN = 4'd1;
  localparam logic [3:0] CHANNEL_MAX = 4'd14;

  // channel hop order while scanning, the pattern continues past entry 19
  localparam logic [3:0] SCAN_TABLE [32] = '{
    4'd1, 4'd6, 4'd11, 4'd2, 4'd3, 4'd7, 4'd8, 4'd1, 4'd6, 4'd11, 4'd4, 4'd5,
    4'd9, 4'd10, 4'd1, 4'd6, 4'd11, 4'd12, 4'd13,
    4'd1, 4'd6, 4'd11, 4'd2, 4'd3, 4'd7, 4'd8, 4'd1, 4'd6, 4'd11, 4'd4, 4'd5, 4'd9
  };

  typedef enum logic [5:0] {
    MODE_DISABLED   = 6'b000001,
    MODE_NORMAL     = 6'b000010,
    MODE_SCAN       = 6'b000100,
    MODE_ASSOCIATE  = 6'b001000,
    MODE_ASSOCIATED = 6'b010000,
    MODE_CANNOT     = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [7:0]  max_assoc_retry;
    logic [15:0] scan_dwell;
    logic [15:0] assoc_retry_interval;
    logic [15:0] keepalive_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_mode;
    logic        req_connect;
    logic        req_copy;
    logic        req_adhoc;
    logic [3:0]  new_ap_channel;
    logic [15:0] coarse_time;
    logic        auth_update;
    logic [1:0]  auth_new_level;
    logic        tx_activity;
  } item_t;

  typedef struct packed {
    logic [2:0] mode_now;
    logic [1:0] led_pattern;
    logic       start_radio;
    logic       stop_radio;
    logic       apply_connect;
    logic       apply_disconnect;
    logic       send_auth;
    logic       send_assoc;
    logic       send_null;
    logic       channel_change;
    logic [3:0] channel;
    logic [1:0] auth_level;
  } result_t;

  // link state apart from the parameter-sized time mark and scan position
  typedef struct packed {
    mode_t       mode;
    logic [1:0]  auth;
    logic [7:0]  retry;
    logic [15:0] keepalive;
    logic [3:0]  ap_channel;
    logic [3:0]  tuned_channel;
    logic [3:0]  wanted_channel;
    logic        adhoc;
    logic        connected;
  } link_state_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    case (m)
      MODE_NORMAL:     c = MODE_CODE_NORMAL;
      MODE_SCAN:       c = MODE_CODE_SCAN;
      MODE_ASSOCIATE:  c = MODE_CODE_ASSOCIATE;
      MODE_ASSOCIATED: c = MODE_CODE_ASSOCIATED;
      MODE_CANNOT:     c = MODE_CODE_CANNOT;
      default:         c = MODE_CODE_DISABLED;
    endcase
    return c;
  endfunction

endpackage

/* design/wifi_station_link_manager.sv */
// wifi_station_link_manager: top level with input register, link state and result register
// depends on wslm_pkg, wslm_cfg and wslm_step
`timescale 1ns / 1ps

// One request (tick) per clock while results are taken: a request is held
// in an input register, the whole mode step runs as combinational logic,
// and its result lands in an output register; a new tick is accepted every
// cycle while results are taken.
// A stalled result holds the input register, which in turn holds in_ready low.
// The link state (mode, auth level, timers, scan position, channels) updates
// when a request moves into the output register. Configuration writes are
// accepted every cycle on the cfg port and should be made while the block is
// idle.
module wifi_station_link_manager import wslm_pkg::*; #(
  parameter int SCAN_LIST_LEN = SCAN_LIST_LEN_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // tick requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_mode,
  input  logic        in_req_connect,
  input  logic        in_req_copy,
  input  logic        in_req_adhoc,
  input  logic [3:0]  in_new_ap_channel,
  input  logic [15:0] in_coarse_time,
  input  logic        in_auth_update,
  input  logic [1:0]  in_auth_new_level,
  input  logic        in_tx_activity,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_mode_now,
  output logic [1:0]  out_led_pattern,
  output logic        out_start_radio,
  output logic        out_stop_radio,
  output logic        out_apply_connect,
  output logic        out_apply_disconnect,
  output logic        out_send_auth,
  output logic        out_send_assoc,
  output logic        out_send_null,
  output logic        out_channel_change,
  output logic [3:0]  out_channel,
  output logic [1:0]  out_auth_level
);

  localparam int SPW = (SCAN_LIST_LEN > 1) ? $clog2(SCAN_LIST_LEN) : 1;

  cfg_t                 cfg;
  item_t                in_item;
  item_t                item_r;
  logic                 item_valid_r;
  logic                 advance;
  link_state_t          st_r;
  link_state_t          st_nxt;
  logic [TIME_BITS-1:0] mark_r;
  logic [TIME_BITS-1:0] mark_nxt;
  logic [SPW-1:0]       pos_r;
  logic [SPW-1:0]       pos_nxt;
  result_t              res_nxt;
  result_t              res_r;
  logic                 out_valid_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  wslm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // pack the incoming request
  assign in_item.req_mode       = in_req_mode;
  assign in_item.req_connect    = in_req_connect;
  assign in_item.req_copy       = in_req_copy;
  assign in_item.req_adhoc      = in_req_adhoc;
  assign in_item.new_ap_channel = in_new_ap_channel;
  assign in_item.coarse_time    = in_coarse_time;
  assign in_item.auth_update    = in_auth_update;
  assign in_item.auth_new_level = in_auth_new_level;
  assign in_item.tx_activity    = in_tx_activity;

  // pipeline flow control
  assign advance  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  // one tick of the mode controller
  wslm_step #(
    .SCAN_LIST_LEN (SCAN_LIST_LEN),
    .TIME_BITS     (TIME_BITS),
    .SPW           (SPW)
  ) u_step (
    .cfg      (cfg),
    .item     (item_r),
    .st_in    (st_r),
    .mark_in  (mark_r),
    .pos_in   (pos_r),
    .st_out   (st_nxt),
    .mark_out (mark_nxt),
    .pos_out  (pos_nxt),
    .res      (res_nxt)
  );

  // link state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode           <= MODE_DISABLED;
      st_r.auth           <= AUTH_DISCONNECTED;
      st_r.retry          <= '0;
      st_r.keepalive      <= '0;
      st_r.ap_channel     <= CHANNEL_MIN;
      st_r.tuned_channel  <= CHANNEL_MIN;
      st_r.wanted_channel <= CHANNEL_MIN;
      st_r.adhoc          <= 1'b0;
      st_r.connected      <= 1'b0;
      mark_r              <= '0;
      pos_r               <= '0;
    end else if (advance) begin
      st_r   <= st_nxt;
      mark_r <= mark_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_mode_now         = res_r.mode_now;
  assign out_led_pattern      = res_r.led_pattern;
  assign out_start_radio      = res_r.start_radio;
  assign out_stop_radio       = res_r.stop_radio;
  assign out_apply_connect    = res_r.apply_connect;
  assign out_apply_disconnect = res_r.apply_disconnect;
  assign out_send_auth        = res_r.send_auth;
  assign out_send_assoc       = res_r.send_assoc;
  assign out_send_null        = res_r.send_null;
  assign out_channel_change   = res_r.channel_change;
  assign out_channel          = res_r.channel;
  assign out_auth_level       = res_r.auth_level;

  // radio start only leaves the disabled mode for normal
  a_start_from_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_start_radio |->
      out_mode_now == MODE_CODE_NORMAL && out_led_pattern == LED_ON)
    else $error("start_radio outside a disabled-to-normal step");

  // a connect always retunes the radio
  a_connect_tunes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_apply_connect |-> out_channel_change && !out_send_assoc)
    else $error("apply_connect without channel change");

  // the associated mode is only held at full auth level
  a_associated_auth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_now == MODE_CODE_ASSOCIATED |-> out_auth_level == AUTH_ASSOCIATED)
    else $error("associated mode with auth level below associated");

  // a result held back keeps the step from running, so state does not move
  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(st_r) && $stable(mark_r))
    else $error("link state moved while result was stalled");

endmodule

/* design/wslm_cfg.sv */
// wslm_cfg: configuration register file of the station link manager
// depends on wslm_pkg for register indexes, reset values and cfg_t
`timescale 1ns / 1ps

module wslm_cfg import wslm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // decode one register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_MAX_ASSOC_RETRY:      cfg_nxt.max_assoc_retry      = wr_data[7:0];
        REG_SCAN_DWELL:           cfg_nxt.scan_dwell           = wr_data;
        REG_ASSOC_RETRY_INTERVAL: cfg_nxt.assoc_retry_interval = wr_data;
        REG_KEEPALIVE_LIMIT:      cfg_nxt.keepalive_limit      = wr_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_assoc_retry      <= MAX_ASSOC_RETRY_RST;
      cfg_r.scan_dwell           <= SCAN_DWELL_RST;
      cfg_r.assoc_retry_interval <= ASSOC_RETRY_INTERVAL_RST;
      cfg_r.keepalive_limit      <= KEEPALIVE_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/wslm_step.sv */
// wslm_step: next-state and result logic for one tick of the link manager
// depends on wslm_pkg for state, item, result and configuration types
`timescale 1ns / 1ps

module wslm_step import wslm_pkg::*; #(
  parameter int SCAN_LIST_LEN = SCAN_LIST_LEN_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF,
  parameter int SPW           = (SCAN_LIST_LEN > 1) ? $clog2(SCAN_LIST_LEN) : 1
) (
  input  cfg_t                 cfg,
  input  item_t                item,
  input  link_state_t          st_in,
  input  logic [TIME_BITS-1:0] mark_in,
  input  logic [SPW-1:0]       pos_in,
  output link_state_t          st_out,
  output logic [TIME_BITS-1:0] mark_out,
  output logic [SPW-1:0]       pos_out,
  output result_t              res
);

  localparam logic [SPW:0] POS_LIMIT = (SPW+1)'(SCAN_LIST_LEN);

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] elapsed;
  logic                 dwell_passed;
  logic                 retry_passed;
  logic [3:0]           new_ch;
  logic [SPW:0]         pos_inc;
  logic [SPW-1:0]       pos_wrap;
  link_state_t          st;

  // elapsed time since the mark, modulo the timer width
  assign now          = TIME_BITS'(item.coarse_time);
  assign elapsed      = now - mark_in;
  assign dwell_passed = 32'(elapsed) > 32'(cfg.scan_dwell);
  assign retry_passed = 32'(elapsed) > 32'(cfg.assoc_retry_interval);

  // clamp the offered channel into 1..14
  always_comb begin
    new_ch = item.new_ap_channel;
    if (new_ch < CHANNEL_MIN) new_ch = CHANNEL_MIN;
    if (new_ch > CHANNEL_MAX) new_ch = CHANNEL_MAX;
  end

  // scan position advance with wrap at the list length
  assign pos_inc  = {1'b0, pos_in} + 1'b1;
  assign pos_wrap = (pos_inc >= POS_LIMIT) ? '0 : pos_inc[SPW-1:0];

  // mode controller
  always_comb begin
    st       = st_in;
    mark_out = mark_in;
    pos_out  = pos_in;
    res      = '0;

    // events reported since the last tick
    if (item.auth_update) st.auth = item.auth_new_level;
    if (item.tx_activity) st.keepalive = '0;

    case (st_in.mode)
      MODE_NORMAL: begin
        res.led_pattern = LED_SLOW;
        if (item.req_mode == REQ_DISABLED) begin
          res.stop_radio = 1'b1;
          st.mode        = MODE_DISABLED;
        end else if (item.req_mode == REQ_SCAN) begin
          mark_out = now;
          st.mode  = MODE_SCAN;
        end else begin
          if (st_in.connected) begin
            res.apply_disconnect = 1'b1;
            st.connected         = 1'b0;
          end
          if (item.req_connect) begin
            if (item.req_copy) begin
              st.ap_channel = new_ch;
              st.adhoc      = item.req_adhoc;
            end
            res.apply_connect  = 1'b1;
            st.wanted_channel  = st.ap_channel;
            st.tuned_channel   = st.ap_channel;
            res.channel_change = 1'b1;
            if (st.adhoc) begin
              st.auth = AUTH_ASSOCIATED;
            end else begin
              res.send_auth = 1'b1;
              st.auth       = AUTH_DISCONNECTED;
            end
            st.connected = 1'b1;
            mark_out     = now;
            st.mode      = MODE_ASSOCIATE;
            st.retry     = '0;
          end
        end
      end
      MODE_SCAN: begin
        res.led_pattern = LED_SLOW;
        if (item.req_mode != REQ_SCAN) begin
          st.mode = MODE_NORMAL;
        end else if (dwell_passed) begin
          mark_out          = now;
          st.wanted_channel = SCAN_TABLE[5'(pos_in)];
          pos_out           = pos_wrap;
        end
      end
      MODE_ASSOCIATE: begin
        res.led_pattern = LED_SLOW;
        if (st.auth == AUTH_ASSOCIATED) begin
          st.mode = MODE_ASSOCIATED;
        end else if (retry_passed && (st_in.retry >= cfg.max_assoc_retry)) begin
          // give up, saturating retry count
          mark_out = now;
          if (st_in.retry != 8'hFF) st.retry = st_in.retry + 8'd1;
          st.mode = MODE_CANNOT;
        end else begin
          if (retry_passed) begin
            mark_out = now;
            st.retry = st_in.retry + 8'd1;
            if (st.auth == AUTH_DISCONNECTED) begin
              if (!st.adhoc) res.send_auth = 1'b1;
              else           st.auth = AUTH_ASSOCIATED;
            end else if (st.auth == AUTH_DEASSOC || st.auth == AUTH_AUTHENTIC) begin
              res.send_assoc = 1'b1;
            end
          end
          if (!item.req_connect) st.mode = MODE_NORMAL;
        end
      end
      MODE_ASSOCIATED: begin
        res.led_pattern = LED_FAST;
        if (st.keepalive >= cfg.keepalive_limit) begin
          st.keepalive  = '0;
          res.send_null = 1'b1;
        end else begin
          st.keepalive = st.keepalive + 16'd1;
        end
        if (!item.req_connect)              st.mode = MODE_NORMAL;
        else if (st.auth != AUTH_ASSOCIATED) st.mode = MODE_ASSOCIATE;
      end
      MODE_CANNOT: begin
        res.led_pattern = LED_SLOW;
        if (!item.req_connect) st.mode = MODE_NORMAL;
      end
      default: begin
        res.led_pattern = LED_ON;
        st.mode         = MODE_DISABLED;
        if (item.req_mode != REQ_DISABLED) begin
          res.start_radio = 1'b1;
          st.mode         = MODE_NORMAL;
        end
      end
    endcase

    // retune when the wanted channel moved
    if (st.tuned_channel != st.wanted_channel) begin
      st.tuned_channel   = st.wanted_channel;
      res.channel_change = 1'b1;
    end

    res.mode_now   = mode_code(st.mode);
    res.channel    = st.tuned_channel;
    res.auth_level = st.auth;
    st_out         = st;
  end

endmodule

/* tb/sv/testbench.sv */
// testbench: self-checking bench for wifi_station_link_manager, tick requests against a
// cycle-free link predictor; opening table then random phases across register settings
// depends on wslm_pkg and wifi_station_link_manager
`timescale 1ns / 1ps

module testbench;
  import wslm_pkg::*;

  // request codes the package leaves unnamed
  localparam logic [1:0] REQ_NORMAL     = 2'd1;
  localparam logic [1:0] REQ_MODE_THREE = 2'd3;

  // strobe masks, in result field order
  localparam logic [7:0] F_START = 8'b1000_0000;
  localparam logic [7:0] F_STOP  = 8'b0100_0000;
  localparam logic [7:0] F_CONN  = 8'b0010_0000;
  localparam logic [7:0] F_DISC  = 8'b0001_0000;
  localparam logic [7:0] F_AUTH  = 8'b0000_1000;
  localparam logic [7:0] F_CHG   = 8'b0000_0001;

  // channel hop order while scanning
  localparam int HOP_COUNT = 19;
  localparam logic [3:0] HOP_ORDER [HOP_COUNT] = '{
    4'd1, 4'd6, 4'd11, 4'd2, 4'd3, 4'd7, 4'd8, 4'd1, 4'd6, 4'd11,
    4'd4, 4'd5, 4'd9, 4'd10, 4'd1, 4'd6, 4'd11, 4'd12, 4'd13
  };

  localparam int PHASES          = 8;
  localparam int TICKS_PER_PHASE = 125;
  localparam int QUIET_PHASE     = 3;
  localparam result_t NO_RESULT  = '0;

  typedef struct packed {
    logic    typed;
    result_t answer;
  } tick_note_t;

  typedef struct packed {
    logic    typed;
    item_t   stim;
    result_t answer;
  } opening_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_mode = '0;
  logic        in_req_connect = 1'b0;
  logic        in_req_copy = 1'b0;
  logic        in_req_adhoc = 1'b0;
  logic [3:0]  in_new_ap_channel = '0;
  logic [15:0] in_coarse_time = '0;
  logic        in_auth_update = 1'b0;
  logic [1:0]  in_auth_new_level = '0;
  logic        in_tx_activity = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_mode_now;
  logic [1:0]  out_led_pattern;
  logic        out_start_radio;
  logic        out_stop_radio;
  logic        out_apply_connect;
  logic        out_apply_disconnect;
  logic        out_send_auth;
  logic        out_send_assoc;
  logic        out_send_null;
  logic        out_channel_change;
  logic [3:0]  out_channel;
  logic [1:0]  out_auth_level;

  wifi_station_link_manager u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_mode          (in_req_mode),
    .in_req_connect       (in_req_connect),
    .in_req_copy          (in_req_copy),
    .in_req_adhoc         (in_req_adhoc),
    .in_new_ap_channel    (in_new_ap_channel),
    .in_coarse_time       (in_coarse_time),
    .in_auth_update       (in_auth_update),
    .in_auth_new_level    (in_auth_new_level),
    .in_tx_activity       (in_tx_activity),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_mode_now         (out_mode_now),
    .out_led_pattern      (out_led_pattern),
    .out_start_radio      (out_start_radio),
    .out_stop_radio       (out_stop_radio),
    .out_apply_connect    (out_apply_connect),
    .out_apply_disconnect (out_apply_disconnect),
    .out_send_auth        (out_send_auth),
    .out_send_assoc       (out_send_assoc),
    .out_send_null        (out_send_null),
    .out_channel_change   (out_channel_change),
    .out_channel          (out_channel),
    .out_auth_level       (out_auth_level)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // link predictor: registers and state, starting from reset values
  logic [7:0]  lm_max_retry  = MAX_ASSOC_RETRY_RST;
  logic [15:0] lm_dwell      = SCAN_DWELL_RST;
  logic [15:0] lm_retry_ivl  = ASSOC_RETRY_INTERVAL_RST;
  logic [15:0] lm_keep_limit = KEEPALIVE_LIMIT_RST;
  logic [2:0]  lm_mode       = MODE_CODE_DISABLED;
  logic [1:0]  lm_auth       = AUTH_DISCONNECTED;
  logic [7:0]  lm_retry      = '0;
  logic [15:0] lm_mark       = '0;
  logic [15:0] lm_keep       = '0;
  logic [4:0]  lm_hop        = '0;
  logic [3:0]  lm_ap         = CHANNEL_MIN;
  logic [3:0]  lm_tuned      = CHANNEL_MIN;
  logic [3:0]  lm_wanted     = CHANNEL_MIN;
  logic        lm_adhoc      = 1'b0;
  logic        lm_connected  = 1'b0;

  // bookkeeping
  tick_note_t known_answers[$];
  result_t    predicted_results[$];
  int         ticks_sent = 0;
  int         results_seen = 0;
  int         mismatch_count = 0;
  int         give_ups = 0;
  int         null_frames = 0;
  int         retunes = 0;
  int         settings_used = 1;
  bit         gaps_on = 1'b1;
  bit         stall_on = 1'b1;
  int         sink_hold = 0;

  // random stimulus state: sticky mode and connect, slowly advancing clock
  logic [1:0]  stim_mode = REQ_NORMAL;
  logic        stim_connect = 1'b0;
  logic [15:0] stim_clock = '0;

  // wrapping elapsed time against an interval
  function automatic logic interval_over(logic [15:0] now, logic [15:0] span);
    logic [15:0] gone;
    gone = now - lm_mark;
    return gone > span;
  endfunction

  // one tick of the link controller
  function automatic result_t advance_link(item_t t);
    result_t    r;
    logic [3:0] ch;
    logic       gave_up;
    r = '0;
    gave_up = 1'b0;
    ch = t.new_ap_channel;
    if (ch < CHANNEL_MIN) ch = CHANNEL_MIN;
    if (ch > CHANNEL_MAX) ch = CHANNEL_MAX;
    // events since the last tick come first
    if (t.auth_update) lm_auth = t.auth_new_level;
    if (t.tx_activity) lm_keep = '0;
    case (lm_mode)
      MODE_CODE_NORMAL: begin
        r.led_pattern = LED_SLOW;
        if (t.req_mode == REQ_DISABLED) begin
          r.stop_radio = 1'b1;
          lm_mode = MODE_CODE_DISABLED;
        end else if (t.req_mode == REQ_SCAN) begin
          lm_mark = t.coarse_time;
          lm_mode = MODE_CODE_SCAN;
        end else begin
          if (lm_connected) begin
            r.apply_disconnect = 1'b1;
            lm_connected = 1'b0;
          end
          if (t.req_connect) begin
            if (t.req_copy) begin
              lm_ap = ch;
              lm_adhoc = t.req_adhoc;
            end
            // connect always retunes, even to the same channel
            r.apply_connect = 1'b1;
            r.channel_change = 1'b1;
            lm_wanted = lm_ap;
            lm_tuned = lm_ap;
            if (lm_adhoc) begin
              lm_auth = AUTH_ASSOCIATED;
            end else begin
              r.send_auth = 1'b1;
              lm_auth = AUTH_DISCONNECTED;
            end
            lm_connected = 1'b1;
            lm_mark = t.coarse_time;
            lm_retry = '0;
            lm_mode = MODE_CODE_ASSOCIATE;
          end
        end
      end
      MODE_CODE_SCAN: begin
        r.led_pattern = LED_SLOW;
        if (t.req_mode != REQ_SCAN) begin
          lm_mode = MODE_CODE_NORMAL;
        end else if (interval_over(t.coarse_time, lm_dwell)) begin
          lm_mark = t.coarse_time;
          lm_wanted = HOP_ORDER[lm_hop];
          lm_hop = (lm_hop == HOP_COUNT - 1) ? '0 : lm_hop + 1'b1;
        end
      end
      MODE_CODE_ASSOCIATE: begin
        r.led_pattern = LED_SLOW;
        if (lm_auth == AUTH_ASSOCIATED) begin
          lm_mode = MODE_CODE_ASSOCIATED;
        end else begin
          if (interval_over(t.coarse_time, lm_retry_ivl)) begin
            lm_mark = t.coarse_time;
            if (lm_retry >= lm_max_retry) begin
              // out of retries, count saturates
              if (lm_retry != 8'hFF) lm_retry = lm_retry + 1'b1;
              lm_mode = MODE_CODE_CANNOT;
              gave_up = 1'b1;
              give_ups++;
            end else begin
              lm_retry = lm_retry + 1'b1;
              if (lm_auth == AUTH_DISCONNECTED) begin
                if (lm_adhoc) lm_auth = AUTH_ASSOCIATED;
                else r.send_auth = 1'b1;
              end else begin
                r.send_assoc = 1'b1;
              end
            end
          end
          if (!gave_up && !t.req_connect) lm_mode = MODE_CODE_NORMAL;
        end
      end
      MODE_CODE_ASSOCIATED: begin
        r.led_pattern = LED_FAST;
        if (lm_keep >= lm_keep_limit) begin
          lm_keep = '0;
          r.send_null = 1'b1;
        end else begin
          lm_keep = lm_keep + 1'b1;
        end
        if (!t.req_connect) lm_mode = MODE_CODE_NORMAL;
        else if (lm_auth != AUTH_ASSOCIATED) lm_mode = MODE_CODE_ASSOCIATE;
      end
      MODE_CODE_CANNOT: begin
        r.led_pattern = LED_SLOW;
        if (!t.req_connect) lm_mode = MODE_CODE_NORMAL;
      end
      default: begin
        r.led_pattern = LED_ON;
        lm_mode = MODE_CODE_DISABLED;
        if (t.req_mode != REQ_DISABLED) begin
          r.start_radio = 1'b1;
          lm_mode = MODE_CODE_NORMAL;
        end
      end
    endcase
    // follow the wanted channel
    if (lm_tuned != lm_wanted) begin
      lm_tuned = lm_wanted;
      r.channel_change = 1'b1;
    end
    r.mode_now = lm_mode;
    r.channel = lm_tuned;
    r.auth_level = lm_auth;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s = %0d, expected %0d",
                                results_seen, name, got, want));
  endtask

  // gap length: mostly short, now and then long
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // result side: random stalls on out_ready
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (stall_on && $urandom_range(0, 4) == 0) sink_hold <= idle_len();
    end
  end

  // watch all three channels: predict on request, compare on result
  always @(posedge clk) begin : watch
    item_t      seen;
    result_t    pred;
    result_t    want;
    tick_note_t note;
    if (rst_n) begin
      if (cfg_valid && cfg_ready === 1'b1) begin
        case (cfg_index)
          REG_MAX_ASSOC_RETRY:      lm_max_retry = cfg_wdata[7:0];
          REG_SCAN_DWELL:           lm_dwell = cfg_wdata;
          REG_ASSOC_RETRY_INTERVAL: lm_retry_ivl = cfg_wdata;
          REG_KEEPALIVE_LIMIT:      lm_keep_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready === 1'b1) begin
        seen = {in_req_mode, in_req_connect, in_req_copy, in_req_adhoc, in_new_ap_channel,
                in_coarse_time, in_auth_update, in_auth_new_level, in_tx_activity};
        pred = advance_link(seen);
        if (pred.send_null) null_frames++;
        if (pred.channel_change) retunes++;
        note = known_answers.pop_front();
        predicted_results.push_back(note.typed ? note.answer : pred);
      end
      if (out_valid === 1'b1 && out_ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    results_seen));
        end else begin
          want = predicted_results.pop_front();
          check_field("mode_now", 4'(out_mode_now), 4'(want.mode_now));
          check_field("led_pattern", 4'(out_led_pattern), 4'(want.led_pattern));
          check_field("start_radio", 4'(out_start_radio), 4'(want.start_radio));
          check_field("stop_radio", 4'(out_stop_radio), 4'(want.stop_radio));
          check_field("apply_connect", 4'(out_apply_connect), 4'(want.apply_connect));
          check_field("apply_disconnect", 4'(out_apply_disconnect),
                      4'(want.apply_disconnect));
          check_field("send_auth", 4'(out_send_auth), 4'(want.send_auth));
          check_field("send_assoc", 4'(out_send_assoc), 4'(want.send_assoc));
          check_field("send_null", 4'(out_send_null), 4'(want.send_null));
          check_field("channel_change", 4'(out_channel_change), 4'(want.channel_change));
          check_field("channel", out_channel, want.channel);
          check_field("auth_level", 4'(out_auth_level), 4'(want.auth_level));
        end
        results_seen++;
      end
    end
  end

  // one tick request, then maybe a gap
  task automatic send_tick(item_t t, logic typed, result_t answer);
    int gap;
    known_answers.push_back({typed, answer});
    in_valid          <= 1'b1;
    in_req_mode       <= t.req_mode;
    in_req_connect    <= t.req_connect;
    in_req_copy       <= t.req_copy;
    in_req_adhoc      <= t.req_adhoc;
    in_new_ap_channel <= t.new_ap_channel;
    in_coarse_time    <= t.coarse_time;
    in_auth_update    <= t.auth_update;
    in_auth_new_level <= t.auth_new_level;
    in_tx_activity    <= t.tx_activity;
    do @(posedge clk); while (in_ready !== 1'b1);
    ticks_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = idle_len();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending until every result is back
  task automatic wait_idle();
    if (results_seen < ticks_sent) begin
      in_valid <= 1'b0;
      while (results_seen < ticks_sent) @(posedge clk);
    end
  endtask

  // write all four registers back to back
  task automatic load_settings(logic [7:0] retry_lim, logic [15:0] dwell,
                               logic [15:0] retry_ivl, logic [15:0] keep_lim);
    logic [1:0]  idx [4];
    logic [15:0] val [4];
    idx = '{REG_MAX_ASSOC_RETRY, REG_SCAN_DWELL, REG_ASSOC_RETRY_INTERVAL,
            REG_KEEPALIVE_LIMIT};
    val = '{{8'd0, retry_lim}, dwell, retry_ivl, keep_lim};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic item_t tick(logic [1:0] m, logic conn = 1'b0, logic cp = 1'b0,
                                 logic ah = 1'b0, logic [3:0] ch = CHANNEL_MIN,
                                 logic [15:0] at = '0, logic upd = 1'b0,
                                 logic [1:0] lvl = AUTH_DISCONNECTED, logic tx = 1'b0);
    return {m, conn, cp, ah, ch, at, upd, lvl, tx};
  endfunction

  function automatic result_t want_of(logic [2:0] m, logic [1:0] led, logic [7:0] flags,
                                      logic [3:0] ch, logic [1:0] auth);
    return {m, led, flags, ch, auth};
  endfunction

  // random tick: mostly coherent sessions, some pure noise
  function automatic item_t next_tick();
    item_t t;
    int    pick;
    pick = $urandom_range(0, 8);
    if ($urandom_range(0, 19) == 0)
      stim_mode = (pick == 0) ? REQ_DISABLED : (pick < 6) ? REQ_NORMAL :
                  (pick < 8) ? REQ_SCAN : REQ_MODE_THREE;
    if ($urandom_range(0, 14) == 0) stim_connect = ~stim_connect;
    if ($urandom_range(0, 15) == 0) stim_clock = 16'($urandom);
    else stim_clock = stim_clock + 16'($urandom_range(0, 3));
    t.req_mode       = stim_mode;
    t.req_connect    = stim_connect;
    t.req_copy       = 1'($urandom_range(0, 1));
    t.req_adhoc      = ($urandom_range(0, 2) == 0);
    t.new_ap_channel = 4'($urandom_range(0, 15));
    t.coarse_time    = stim_clock;
    t.auth_update    = ($urandom_range(0, 4) == 0);
    t.auth_new_level = 2'($urandom_range(0, 3));
    t.tx_activity    = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 11) == 0) t = item_t'(29'($urandom));
    return t;
  endfunction

  // stimulus
  initial begin : stimulus
    opening_row_t opening[$];
    logic [7:0]   retry_lim;
    logic [15:0]  dwell;
    logic [15:0]  retry_ivl;
    logic [15:0]  keep_lim;
    int           cap;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // opening table under reset settings; typed answers where they are plain
    opening.push_back({1'b1, tick(REQ_DISABLED),
                       want_of(MODE_CODE_DISABLED, LED_ON, 8'h00, 4'd1, AUTH_DISCONNECTED)});
    opening.push_back({1'b1, tick(REQ_MODE_THREE),
                       want_of(MODE_CODE_NORMAL, LED_ON, F_START, 4'd1, AUTH_DISCONNECTED)});
    opening.push_back({1'b1, tick(REQ_DISABLED),
                       want_of(MODE_CODE_DISABLED, LED_SLOW, F_STOP, 4'd1, AUTH_DISCONNECTED)});
    opening.push_back({1'b0, tick(REQ_NORMAL, 0, 0, 0, 1, 50), NO_RESULT});
    // connect with channel above range
    opening.push_back({1'b1, tick(REQ_NORMAL, 1, 1, 0, 15, 100),
                       want_of(MODE_CODE_ASSOCIATE, LED_SLOW, F_CONN | F_AUTH | F_CHG,
                               CHANNEL_MAX, AUTH_DISCONNECTED)});
    // retries, then association
    opening.push_back({1'b0, tick(REQ_NORMAL, 1, 0, 0, 3, 121), NO_RESULT});
    opening.push_back({1'b0, tick(REQ_NORMAL, 1, 0, 0, 3, 142, 1, AUTH_AUTHENTIC), NO_RESULT});
    opening.push_back({1'b0, tick(REQ_NORMAL, 1, 0, 0, 3, 150, 1, AUTH_ASSOCIATED), NO_RESULT});
    opening.push_back({1'b0, tick(REQ_NORMAL, 1, 0, 0, 3, 16'hFFFF, 0, AUTH_DISCONNECTED, 1),
                       NO_RESULT});
    opening.push_back({1'b0, tick(REQ_NORMAL), NO_RESULT});
    opening.push_back({1'b0, tick(REQ_NORMAL), NO_RESULT});
    // ad-hoc connect with channel below range
    opening.push_back({1'b1, tick(REQ_NORMAL, 1, 1, 1, 0, 0),
                       want_of(MODE_CODE_ASSOCIATE, LED_SLOW, F_CONN | F_CHG,
                               CHANNEL_MIN, AUTH_ASSOCIATED)});
    opening.push_back({1'b0, tick(REQ_NORMAL, 1, 0, 0, 1, 5), NO_RESULT});
    opening.push_back({1'b0, tick(REQ_NORMAL), NO_RESULT});
    // scan a few hops
    opening.push_back({1'b0, tick(REQ_SCAN, 0, 0, 0, 1, 1000), NO_RESULT});
    opening.push_back({1'b0, tick(REQ_SCAN, 0, 0, 0, 1, 1007), NO_RESULT});
    opening.push_back({1'b0, tick(REQ_SCAN, 0, 0, 0, 1, 1014), NO_RESULT});
    opening.push_back({1'b0, tick(REQ_SCAN, 0, 0, 0, 1, 1014), NO_RESULT});
    opening.push_back({1'b0, tick(REQ_NORMAL), NO_RESULT});
    opening.push_back({1'b0, tick(REQ_NORMAL, 1, 1, 0, 7, 2000, 1, AUTH_DEASSOC), NO_RESULT});
    opening.push_back({1'b0, tick(REQ_NORMAL, 0, 0, 0, 7, 2005), NO_RESULT});
    // radio stop keeps the connection until the normal tick after the radio restarts
    opening.push_back({1'b1, tick(REQ_DISABLED),
                       want_of(MODE_CODE_DISABLED, LED_SLOW, F_STOP, 4'd7, AUTH_DISCONNECTED)});
    opening.push_back({1'b0, tick(REQ_NORMAL), NO_RESULT});
    opening.push_back({1'b1, tick(REQ_NORMAL),
                       want_of(MODE_CODE_NORMAL, LED_SLOW, F_DISC, 4'd7, AUTH_DISCONNECTED)});
    // dwell across the timer wrap
    opening.push_back({1'b0, tick(REQ_SCAN, 0, 0, 0, 1, 16'd65530), NO_RESULT});
    opening.push_back({1'b0, tick(REQ_SCAN, 0, 0, 0, 1, 16'd1), NO_RESULT});
    foreach (opening[i]) send_tick(opening[i].stim, opening[i].typed, opening[i].answer);

    // random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          retry_lim = '0; dwell = '0; retry_ivl = '0; keep_lim = '0;
        end
        1: begin
          retry_lim = '1; dwell = '1; retry_ivl = '1; keep_lim = '1;
        end
        default: begin
          retry_lim = 8'($urandom_range(0, 4));
          dwell     = 16'($urandom_range(0, 6));
          retry_ivl = 16'($urandom_range(0, 8));
          keep_lim  = 16'($urandom_range(0, 15));
        end
      endcase
      load_settings(retry_lim, dwell, retry_ivl, keep_lim);
      settings_used++;
      gaps_on  = (phase != QUIET_PHASE);
      stall_on = (phase != QUIET_PHASE);
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) == 0) wait_idle();
        send_tick(next_tick(), 1'b0, NO_RESULT);
      end
    end

    // drain, then wait on for anything stray
    in_valid <= 1'b0;
    cap = 0;
    while (results_seen < ticks_sent && cap < 20000) begin
      @(posedge clk);
      cap++;
    end
    repeat (8) @(posedge clk);
    if (predicted_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_results.size()));

    $display("checked %0d tick results under %0d register settings, %0d mismatches",
             results_seen, settings_used, mismatch_count);
    $display("keepalive frames %0d, association give-ups %0d, channel changes %0d",
             null_frames, give_ups, retunes);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("watchdog expired with %0d of %0d results back", results_seen, ticks_sent);
    $display("Regression FAIL");
    $finish;
  end

endmodule
